// ===== hw/rtl/sprite_rle_frame_decoder_top_macros.svh =====
// Assertion macros for the sprite frame decoder checker.
`ifndef SPRITE_RLE_FRAME_DECODER_TOP_MACROS_SVH
`define SPRITE_RLE_FRAME_DECODER_TOP_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define SRFD_ASSERT_ALWAYS(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, active through reset.
`define SRFD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/srfd_pkg.sv =====
// Shared constants and types of the sprite frame run-length decoder.
package srfd_pkg;

   localparam int POSITION_BITS = 32;

   localparam int BYTE_W   = 8;
   localparam int DIM_W    = 16;
   localparam int FIELD_W  = 32;
   localparam int STATUS_W = 3;
   localparam int FORMAT_W = 2;
   localparam int CSR_IDX_W = 2;

   localparam logic [FORMAT_W-1:0] FMT_RLE  = 2'd0;
   localparam logic [FORMAT_W-1:0] FMT_MASK = 2'd1;

   localparam logic [CSR_IDX_W-1:0] CSR_FORMAT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
   localparam logic [STATUS_W-1:0] ST_SIZE         = 3'd1;
   localparam logic [STATUS_W-1:0] ST_LENGTH       = 3'd2;
   localparam logic [STATUS_W-1:0] ST_MASK_SIZE    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_ROW_OVERFLOW = 3'd4;

   typedef struct packed {
      logic [BYTE_W-1:0]   pixel_value;
      logic [BYTE_W-1:0]   run_length;
      logic                is_mask;
      logic                end_of_row;
      logic                frame_done;
      logic [STATUS_W-1:0] status;
   } result_type;

endpackage

// ===== hw/rtl/sprite_rle_frame_decoder_top.sv =====
// Sprite frame run-length decoder: byte stream in, pixel runs out.
//
//   channel  direction  ports                      payload
//   req      in         req_tvalid/tready/tdata/tlast  coded byte, last byte of frame
//   rsp      out        rsp_tvalid/tready/tdata/tuser/tlast  run, row/status, mask flag
//   csr      in         csr_valid/ready/index/data  format, width, height writes
//
// One byte per cycle while req_tready is high; each byte is decoded in the cycle
// it is accepted and its result is registered on that edge, in the output
// register or, while that one is held, in the skid entry.
// A two-entry output buffer (output register plus skid) keeps input flowing
// while one result waits; req_tready drops only when both entries are full.
// Reset (synchronous, active high) clears frame state, registers and buffers.
// The csr port is always ready; writes take effect on the next byte.
module sprite_rle_frame_decoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] pixel_value, [15:8] run_length,
                                    // [16] end_of_row, [19:17] status, [23:20] zero
   output logic        rsp_tuser,   // [0] is_mask
   output logic        rsp_tlast,   // frame_done
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int POS_W = srfd_pkg::POSITION_BITS;

   typedef enum logic [2:0] {
      PH_HEAD_A   = 3'd0,
      PH_HEAD_B   = 3'd1,
      PH_ROWCOUNT = 3'd2,
      PH_CONTROL  = 3'd3,
      PH_LITERAL  = 3'd4,
      PH_PASS     = 3'd5,
      PH_DONE     = 3'd6,
      PH_DRAIN    = 3'd7
   } phase_type;

   logic [1:0]  format_ff;
   logic [15:0] width_ff;
   logic [15:0] height_ff;

   phase_type        phase_ff, phase_in;
   logic [23:0]      shift_ff, shift_in;
   logic [1:0]       fidx_ff, fidx_in;
   logic [31:0]      rowleft_ff, rowleft_in;
   logic [7:0]       lit_ff, lit_in;
   logic [15:0]      row_ff, row_in;
   logic [16:0]      col_ff, col_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [31:0]      mseen_ff, mseen_in;
   logic [2:0]       err_ff, err_in;

   srfd_pkg::result_type out_ff, skid_ff, res;
   logic out_vld_ff, skid_vld_ff;

   logic        have;
   logic        rle, raw;
   logic        in_field, fld_done;
   logic [31:0] fld_val;
   logic        neg;
   logic [7:0]  mag;
   logic [31:0] rbl_dec;
   logic [17:0] col_sum;
   logic        over;
   logic [16:0] col_p1;
   logic [15:0] row_inc;
   logic [7:0]  lit_dec;
   logic        raise_req, end_row_req, begin_req, finish_req, ok_end;
   logic [2:0]  raise_code;
   logic        accept, push, pop;

   assign rle      = format_ff == srfd_pkg::FMT_RLE;
   assign raw      = format_ff[1];
   assign in_field = !raw && (phase_ff == PH_HEAD_A || phase_ff == PH_HEAD_B ||
                              phase_ff == PH_ROWCOUNT);
   assign fld_done = fidx_ff == 2'd3;
   assign fld_val  = {req_tdata, shift_ff};
   assign neg      = req_tdata[7];
   assign mag      = neg ? (8'd0 - req_tdata) : req_tdata;
   assign rbl_dec  = rowleft_ff - 32'd1;
   assign col_sum  = {1'b0, col_ff} + {10'd0, mag};
   assign over     = col_sum > {2'b00, width_ff};
   assign col_p1   = col_ff + 17'd1;
   assign row_inc  = row_ff + 16'd1;
   assign lit_dec  = lit_ff - 8'd1;

   always_comb begin
      phase_in   = phase_ff;
      shift_in   = shift_ff;
      fidx_in    = fidx_ff;
      rowleft_in = rowleft_ff;
      lit_in     = lit_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      pos_in     = pos_ff + {{(POS_W-1){1'b0}}, 1'b1};
      mseen_in   = mseen_ff;
      err_in     = err_ff;
      res        = '0;
      res.is_mask = format_ff == srfd_pkg::FMT_MASK &&
                    (phase_ff == PH_HEAD_A || phase_ff == PH_HEAD_B ||
                     phase_ff == PH_ROWCOUNT || phase_ff == PH_CONTROL);
      have        = 1'b0;
      raise_req   = 1'b0;
      raise_code  = srfd_pkg::ST_OK;
      end_row_req = 1'b0;
      begin_req   = 1'b0;
      finish_req  = 1'b0;
      ok_end      = 1'b0;

      if (in_field) begin
         if (fld_done) begin
            fidx_in  = 2'd0;
            shift_in = '0;
         end else begin
            fidx_in = fidx_ff + 2'd1;
            unique case (fidx_ff)
               2'd0:    shift_in[7:0]   = req_tdata;
               2'd1:    shift_in[15:8]  = req_tdata;
               2'd2:    shift_in[23:16] = req_tdata;
               default: shift_in        = shift_ff;
            endcase
         end
      end

      if (raw) begin
         have            = 1'b1;
         res.pixel_value = req_tdata;
         res.run_length  = 8'd1;
         if (width_ff != 16'd0 && col_p1 >= {1'b0, width_ff}) begin
            res.end_of_row = 1'b1;
            col_in         = '0;
            row_in         = row_inc;
         end else begin
            col_in = col_p1;
         end
      end else begin
         unique case (phase_ff)
            PH_HEAD_A: begin
               if (fld_done) begin
                  if (rle) begin
                     if (fld_val != {16'd0, width_ff}) begin
                        raise_req  = 1'b1;
                        raise_code = srfd_pkg::ST_SIZE;
                     end else begin
                        phase_in = PH_HEAD_B;
                     end
                  end else begin
                     mseen_in  = fld_val;
                     begin_req = 1'b1;
                  end
               end
            end
            PH_HEAD_B: begin
               if (fld_done) begin
                  if (fld_val != {16'd0, height_ff}) begin
                     raise_req  = 1'b1;
                     raise_code = srfd_pkg::ST_SIZE;
                  end else begin
                     begin_req = 1'b1;
                  end
               end
            end
            PH_ROWCOUNT: begin
               if (fld_done) begin
                  rowleft_in  = fld_val;
                  phase_in    = PH_CONTROL;
                  end_row_req = fld_val == 32'd0;
               end
            end
            PH_CONTROL: begin
               rowleft_in = rbl_dec;
               if (!rle || neg) begin
                  if (over) begin
                     raise_req  = 1'b1;
                     raise_code = srfd_pkg::ST_ROW_OVERFLOW;
                  end else begin
                     col_in = col_sum[16:0];
                     if (mag != 8'd0) begin
                        have            = 1'b1;
                        res.pixel_value = (!rle && !neg) ? 8'd1 : 8'd0;
                        res.run_length  = mag;
                     end
                     end_row_req = rbl_dec == 32'd0;
                  end
               end else if ({24'd0, mag} > rbl_dec) begin
                  raise_req  = 1'b1;
                  raise_code = srfd_pkg::ST_LENGTH;
               end else if (over) begin
                  raise_req  = 1'b1;
                  raise_code = srfd_pkg::ST_ROW_OVERFLOW;
               end else if (mag == 8'd0) begin
                  end_row_req = rbl_dec == 32'd0;
               end else begin
                  rowleft_in = rbl_dec - {24'd0, mag};
                  lit_in     = mag;
                  phase_in   = PH_LITERAL;
               end
            end
            PH_LITERAL: begin
               have            = 1'b1;
               res.pixel_value = req_tdata;
               res.run_length  = 8'd1;
               col_in          = col_p1;
               lit_in          = lit_dec;
               if (lit_dec == 8'd0) begin
                  if (rowleft_ff == 32'd0) begin
                     end_row_req = 1'b1;
                  end else begin
                     phase_in = PH_CONTROL;
                  end
               end
            end
            PH_PASS: begin
               have            = 1'b1;
               res.pixel_value = req_tdata;
               res.run_length  = 8'd1;
               if (width_ff != 16'd0 && col_p1 >= {1'b0, width_ff}) begin
                  res.end_of_row = 1'b1;
                  col_in         = '0;
                  row_in         = row_inc;
               end else begin
                  col_in = col_p1;
               end
            end
            PH_DONE: begin
               raise_req  = 1'b1;
               raise_code = srfd_pkg::ST_LENGTH;
            end
            PH_DRAIN: begin
               have = 1'b0;
            end
            default: begin
               have = 1'b0;
            end
         endcase
      end

      if (begin_req) begin
         row_in = '0;
         col_in = '0;
         if (height_ff == 16'd0) begin
            finish_req = 1'b1;
         end else begin
            phase_in = PH_ROWCOUNT;
         end
      end

      if (end_row_req) begin
         res.end_of_row = 1'b1;
         have           = 1'b1;
         col_in         = '0;
         row_in         = row_inc;
         if (row_inc == height_ff) begin
            finish_req = 1'b1;
         end else begin
            phase_in = PH_ROWCOUNT;
         end
      end

      if (finish_req) begin
         col_in = '0;
         row_in = '0;
         if (rle) begin
            phase_in = PH_DONE;
         end else if (mseen_in[POS_W-1:0] != pos_in) begin
            raise_req  = 1'b1;
            raise_code = srfd_pkg::ST_MASK_SIZE;
         end else begin
            phase_in = PH_PASS;
         end
      end

      if (raise_req) begin
         if (err_ff == srfd_pkg::ST_OK) begin
            err_in = raise_code;
         end
         res.status = raise_code;
         have       = 1'b1;
         phase_in   = PH_DRAIN;
      end

      if (req_tlast) begin
         ok_end         = raw || (rle ? phase_in == PH_DONE : phase_in == PH_PASS);
         have           = 1'b1;
         res.frame_done = 1'b1;
         res.status     = (err_in != srfd_pkg::ST_OK) ? err_in :
                          (ok_end ? srfd_pkg::ST_OK : srfd_pkg::ST_LENGTH);
         phase_in   = PH_HEAD_A;
         shift_in   = '0;
         fidx_in    = '0;
         rowleft_in = '0;
         lit_in     = '0;
         row_in     = '0;
         col_in     = '0;
         pos_in     = '0;
         mseen_in   = '0;
         err_in     = srfd_pkg::ST_OK;
      end
   end

   assign req_tready = !skid_vld_ff;
   assign accept     = req_tvalid && req_tready;
   assign push       = accept && have;
   assign pop        = out_vld_ff && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEAD_A;
         shift_ff    <= '0;
         fidx_ff     <= '0;
         rowleft_ff  <= '0;
         lit_ff      <= '0;
         row_ff      <= '0;
         col_ff      <= '0;
         pos_ff      <= '0;
         mseen_ff    <= '0;
         err_ff      <= srfd_pkg::ST_OK;
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff   <= phase_in;
            shift_ff   <= shift_in;
            fidx_ff    <= fidx_in;
            rowleft_ff <= rowleft_in;
            lit_ff     <= lit_in;
            row_ff     <= row_in;
            col_ff     <= col_in;
            pos_ff     <= pos_in;
            mseen_ff   <= mseen_in;
            err_ff     <= err_in;
         end
         if (skid_vld_ff) begin
            if (pop) begin
               out_ff      <= skid_ff;
               skid_vld_ff <= 1'b0;
            end
         end else if (push) begin
            if (!out_vld_ff || pop) begin
               out_ff     <= res;
               out_vld_ff <= 1'b1;
            end else begin
               skid_ff     <= res;
               skid_vld_ff <= 1'b1;
            end
         end else if (pop) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff <= srfd_pkg::FMT_RLE;
         width_ff  <= '0;
         height_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            srfd_pkg::CSR_FORMAT: format_ff <= csr_data[1:0];
            srfd_pkg::CSR_WIDTH:  width_ff  <= csr_data;
            srfd_pkg::CSR_HEIGHT: height_ff <= csr_data;
            default:              format_ff <= format_ff;
         endcase
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {4'd0, out_ff.status, out_ff.end_of_row, out_ff.run_length,
                        out_ff.pixel_value};
   assign rsp_tuser  = out_ff.is_mask;
   assign rsp_tlast  = out_ff.frame_done;

endmodule

// ===== hw/rtl/srfd_checker.sv =====
// Port-level checker for the sprite frame decoder, bound to the top level.
`include "sprite_rle_frame_decoder_top_macros.svh"

module srfd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   `SRFD_ASSERT_NEXT(a_rsp_hold, !reset && rsp_tvalid && !rsp_tready, reset || (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast)), "stalled rsp transaction changed")
   `SRFD_ASSERT_NEXT(a_reset_empty, reset, !rsp_tvalid && req_tready, "buffers not empty after reset")
   `SRFD_ASSERT_ALWAYS(a_ready_when_empty, !rsp_tvalid, req_tready, "req stalled with empty output")
   `SRFD_ASSERT_ALWAYS(a_status_only_eor, rsp_tvalid && rsp_tdata[15:8] == 8'd0 && rsp_tdata[19:17] == srfd_pkg::ST_OK && !rsp_tlast, rsp_tdata[16], "empty ok run without end of row")
   `SRFD_ASSERT_ALWAYS(a_rsp_range, rsp_tvalid, rsp_tdata[19:17] <= srfd_pkg::ST_ROW_OVERFLOW && rsp_tdata[15:8] <= 8'd128 && rsp_tdata[23:20] == 4'd0, "rsp field out of range")

endmodule

bind sprite_rle_frame_decoder_top srfd_checker u_srfd_checker (.*);
